>>> src/modexp_pkg.sv
// ============================================================================
// modexp_pkg
// Shared constants, microcode codes and control store for the modular
// exponentiation unit.
// ============================================================================
`default_nettype none

package modexp_pkg;

    // Default field widths
    localparam int MOD_BITS_DEF = 62;
    localparam int EXP_BITS_DEF = 63;

    // Sequencer program counter
    localparam int PC_BITS = 4;

    // Step addresses of the program
    localparam logic [PC_BITS-1:0] PC_WAIT     = 4'd0;
    localparam logic [PC_BITS-1:0] PC_RED_INIT = 4'd1;
    localparam logic [PC_BITS-1:0] PC_RED_STEP = 4'd2;
    localparam logic [PC_BITS-1:0] PC_RED_DONE = 4'd3;
    localparam logic [PC_BITS-1:0] PC_MUL_INIT = 4'd4;
    localparam logic [PC_BITS-1:0] PC_MUL_STEP = 4'd5;
    localparam logic [PC_BITS-1:0] PC_ACC_LOAD = 4'd6;
    localparam logic [PC_BITS-1:0] PC_SQR_INIT = 4'd7;
    localparam logic [PC_BITS-1:0] PC_SQR_STEP = 4'd8;
    localparam logic [PC_BITS-1:0] PC_POW_LOAD = 4'd9;
    // last address, so falling through wraps straight back to PC_WAIT
    localparam logic [PC_BITS-1:0] PC_OUT      = 4'd15;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_RED_INIT,
        OP_RED_STEP,
        OP_RED_DONE,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_ACC_LOAD,
        OP_SQR_INIT,
        OP_POW_LOAD,
        OP_OUT_LOAD
    } op_t;

    // Jump conditions; a true condition jumps to the target, else fall through
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_SMALL_MOD,
        COND_CNT_NZ,
        COND_EXP_ZERO,
        COND_BIT0_CLR,
        COND_EXP_HIGH_ZERO,
        COND_RSP_FULL
    } cond_t;

    // One control word
    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic [PC_BITS-1:0] target;
    } ctrl_t;

    // Control store
    function automatic ctrl_t ucode(input logic [PC_BITS-1:0] pc);
        ctrl_t w;
        unique case (pc)
            PC_WAIT:     w = '{OP_LOAD,     COND_NO_REQ,        PC_WAIT};
            PC_RED_INIT: w = '{OP_RED_INIT, COND_SMALL_MOD,     PC_OUT};
            PC_RED_STEP: w = '{OP_RED_STEP, COND_CNT_NZ,        PC_RED_STEP};
            PC_RED_DONE: w = '{OP_RED_DONE, COND_EXP_ZERO,      PC_OUT};
            PC_MUL_INIT: w = '{OP_MUL_INIT, COND_BIT0_CLR,      PC_SQR_INIT};
            PC_MUL_STEP: w = '{OP_MUL_STEP, COND_CNT_NZ,        PC_MUL_STEP};
            PC_ACC_LOAD: w = '{OP_ACC_LOAD, COND_NEVER,         PC_WAIT};
            PC_SQR_INIT: w = '{OP_SQR_INIT, COND_EXP_HIGH_ZERO, PC_OUT};
            PC_SQR_STEP: w = '{OP_MUL_STEP, COND_CNT_NZ,        PC_SQR_STEP};
            PC_POW_LOAD: w = '{OP_POW_LOAD, COND_ALWAYS,        PC_MUL_INIT};
            PC_OUT:      w = '{OP_OUT_LOAD, COND_RSP_FULL,      PC_OUT};
            default:     w = '{OP_LOAD,     COND_ALWAYS,        PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/modular_exponentiation_unit.sv
// ============================================================================
// modular_exponentiation_unit
// Right-to-left square-and-multiply modular exponentiation, run by a small
// microcoded sequencer over one shift-and-add modular product datapath.
// ============================================================================
// Sequence: load the base and reduce it mod m, then per exponent bit up to
//   the highest set one: a test, a multiply into the accumulator when the
//   bit is set, and the square of the base (skipped after the top bit);
//   finally the result is posted.
// Throughput: one transaction at a time; the next request is taken while a
//   finished result waits. Reset: rst_n clears the PC and output valid flag.
`default_nettype none

module modular_exponentiation_unit #(
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF,
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [MOD_BITS-1:0] base_value,
    input  wire logic [EXP_BITS-1:0] exponent_value,
    input  wire logic [MOD_BITS:0]   modulus_value,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic [MOD_BITS-1:0]      power_result
);

    localparam int CNT_BITS = $clog2(MOD_BITS);
    localparam logic [MOD_BITS:0] MOD_CAP = {1'b1, {MOD_BITS{1'b0}}};
    localparam logic [MOD_BITS:0] MOD_TWO = (MOD_BITS+1)'(2);

    // x >= m ? x - m : x, with the result known to fit below m
    function automatic logic [MOD_BITS-1:0] mod_fix(
        input logic [MOD_BITS:0] x,
        input logic [MOD_BITS:0] m
    );
        logic [MOD_BITS:0] d;
        d = x - m;
        return (x >= m) ? d[MOD_BITS-1:0] : x[MOD_BITS-1:0];
    endfunction

    // Sequencer and datapath registers
    logic [modexp_pkg::PC_BITS-1:0] pc_reg, pc_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [MOD_BITS-1:0] result_reg, result_next;
    logic [MOD_BITS:0]   mod_reg, mod_next;
    logic                small_reg, small_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] pow_reg, pow_next;
    logic [MOD_BITS-1:0] mul_acc_reg, mul_acc_next;
    logic [MOD_BITS-1:0] mul_add_reg, mul_add_next;
    logic [MOD_BITS-1:0] mul_y_reg, mul_y_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    modexp_pkg::ctrl_t   ctrl;
    logic                req_accept;
    logic                rsp_full;
    logic                jump;
    logic [MOD_BITS:0]   mod_sat;

    assign ctrl       = modexp_pkg::ucode(pc_reg);
    assign req_stall  = (pc_reg != modexp_pkg::PC_WAIT);
    assign req_accept = req_valid && !req_stall;
    assign rsp_full   = rsp_valid_reg && rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign power_result = result_reg;
    assign mod_sat    = (modulus_value > MOD_CAP) ? MOD_CAP : modulus_value;

    // Jump condition select
    always_comb
    begin
        unique case (ctrl.cond)
            modexp_pkg::COND_NEVER:         jump = 1'b0;
            modexp_pkg::COND_ALWAYS:        jump = 1'b1;
            modexp_pkg::COND_NO_REQ:        jump = !req_valid;
            modexp_pkg::COND_SMALL_MOD:     jump = small_reg;
            modexp_pkg::COND_CNT_NZ:        jump = (cnt_reg != '0);
            modexp_pkg::COND_EXP_ZERO:      jump = (exp_reg == '0);
            modexp_pkg::COND_BIT0_CLR:      jump = !exp_reg[0];
            modexp_pkg::COND_EXP_HIGH_ZERO: jump = (exp_reg[EXP_BITS-1:1] == '0);
            modexp_pkg::COND_RSP_FULL:      jump = rsp_full;
            default:                        jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 1'b1;
    end

    // Datapath, one control word per cycle
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        result_next    = result_reg;
        mod_next       = mod_reg;
        small_next     = small_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        pow_next       = pow_reg;
        mul_acc_next   = mul_acc_reg;
        mul_add_next   = mul_add_reg;
        mul_y_next     = mul_y_reg;
        cnt_next       = cnt_reg;

        unique case (ctrl.op)
            modexp_pkg::OP_LOAD:
            begin
                if (req_accept)
                begin
                    mod_next   = mod_sat;
                    small_next = (mod_sat < MOD_TWO);
                    exp_next   = exponent_value;
                    pow_next   = base_value;
                    acc_next   = (mod_sat < MOD_TWO) ? '0 : MOD_BITS'(1);
                end
            end
            modexp_pkg::OP_RED_INIT:
            begin
                mul_acc_next = '0;
                mul_y_next   = pow_reg;
                cnt_next     = CNT_BITS'(MOD_BITS - 1);
            end
            // base mod m, one base bit per cycle from the top
            modexp_pkg::OP_RED_STEP:
            begin
                mul_acc_next = mod_fix({mul_acc_reg, mul_y_reg[MOD_BITS-1]}, mod_reg);
                mul_y_next   = {mul_y_reg[MOD_BITS-2:0], 1'b0};
                cnt_next     = cnt_reg - 1'b1;
            end
            modexp_pkg::OP_RED_DONE:
            begin
                pow_next = mul_acc_reg;
            end
            modexp_pkg::OP_MUL_INIT:
            begin
                mul_acc_next = '0;
                mul_add_next = acc_reg;
                mul_y_next   = pow_reg;
                cnt_next     = CNT_BITS'(MOD_BITS - 1);
            end
            // shift-and-add product step, LSB of the multiplier first
            modexp_pkg::OP_MUL_STEP:
            begin
                if (mul_y_reg[0])
                begin
                    mul_acc_next = mod_fix({1'b0, mul_acc_reg} + {1'b0, mul_add_reg},
                                           mod_reg);
                end
                mul_add_next = mod_fix({mul_add_reg, 1'b0}, mod_reg);
                mul_y_next   = {1'b0, mul_y_reg[MOD_BITS-1:1]};
                cnt_next     = cnt_reg - 1'b1;
            end
            modexp_pkg::OP_ACC_LOAD:
            begin
                acc_next = mul_acc_reg;
            end
            modexp_pkg::OP_SQR_INIT:
            begin
                mul_acc_next = '0;
                mul_add_next = pow_reg;
                mul_y_next   = pow_reg;
                cnt_next     = CNT_BITS'(MOD_BITS - 1);
                exp_next     = {1'b0, exp_reg[EXP_BITS-1:1]};
            end
            modexp_pkg::OP_POW_LOAD:
            begin
                pow_next = mul_acc_reg;
            end
            modexp_pkg::OP_OUT_LOAD:
            begin
                if (!rsp_full)
                begin
                    rsp_valid_next = 1'b1;
                    result_next    = acc_reg;
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= modexp_pkg::PC_WAIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        mod_reg     <= mod_next;
        small_reg   <= small_next;
        exp_reg     <= exp_next;
        acc_reg     <= acc_next;
        pow_reg     <= pow_next;
        mul_acc_reg <= mul_acc_next;
        mul_add_reg <= mul_add_next;
        mul_y_reg   <= mul_y_next;
        cnt_reg     <= cnt_next;
    end

    // Arithmetic steps only run with a usable modulus
    a_mod_usable: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg >= modexp_pkg::PC_RED_STEP && pc_reg <= modexp_pkg::PC_POW_LOAD)
        |-> (mod_reg >= MOD_TWO))
        else $error("modulus below two inside the exponent loop");

    // Operands of each product are reduced
    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == modexp_pkg::PC_MUL_INIT)
        |-> (({1'b0, acc_reg} < mod_reg) && ({1'b0, pow_reg} < mod_reg)))
        else $error("product operand not below modulus");

    // A finished transaction reaches the output register
    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == modexp_pkg::PC_OUT && !rsp_full)
        |=> (rsp_valid && pc_reg == modexp_pkg::PC_WAIT))
        else $error("result not posted at end of program");

endmodule

`default_nettype wire
